FILE: sv/assert_macros.svh
// Assertion macros shared by the vignette pipeline modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check on clk_i, disabled while rst_ni is low.
`define RVP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge.
`define RVP_ASSERT_NEVER(lbl, expr, msg) \
  `RVP_ASSERT(lbl, !(expr), msg)

`endif

FILE: sv/rvp_pkg.sv
// Shared widths, constants and payload types of the radial vignette pipeline.
package rvp_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned DIST_FRAC  = 8;
  localparam int unsigned CH_W       = 8;

  localparam int unsigned REG_W      = COORD_BITS + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned DIFF_W     = COORD_BITS + 1;
  localparam int unsigned SQ_W       = 2 * COORD_BITS;
  localparam int unsigned SUM_W      = SQ_W + 1;
  localparam int unsigned RADICAND_W = SUM_W + 1 + 2 * DIST_FRAC;
  localparam int unsigned ROOT_W     = RADICAND_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 2;

  localparam int unsigned QUO_W      = FRAC_BITS + 2;
  localparam int unsigned NUM_SHIFT  = FRAC_BITS + 1 - DIST_FRAC;
  localparam int unsigned DIV_PRE    = QUO_W - NUM_SHIFT;
  localparam int unsigned DREM_W     = REG_W + 1;
  localparam int unsigned CMP_W      = ROOT_W + REG_W;

  localparam int unsigned GAIN_W       = FRAC_BITS + 2;
  localparam int unsigned NEAR_W       = FRAC_BITS + 1;
  localparam int unsigned RECIP_K      = FRAC_BITS + 5;
  localparam int unsigned RECIP_W      = FRAC_BITS + 2;
  localparam int unsigned RECIP_PROD_W = NEAR_W + RECIP_W;
  localparam int unsigned TENTH_W      = RECIP_PROD_W - RECIP_K;
  localparam int unsigned CHPROD_W     = CH_W + GAIN_W;

  localparam longint unsigned ONE_INT      = 64'd1 << FRAC_BITS;
  localparam longint unsigned TWO_INT      = ONE_INT << 1;
  localparam longint unsigned GAIN_MAX_INT = ONE_INT + ONE_INT / 10;
  localparam longint unsigned RECIP_M_INT  = ((64'd1 << RECIP_K) + 64'd9) / 64'd10;

  localparam logic [QUO_W-1:0]   ONE_Q    = ONE_INT[QUO_W-1:0];
  localparam logic [QUO_W-1:0]   TWO_Q    = TWO_INT[QUO_W-1:0];
  localparam logic [GAIN_W-1:0]  GAIN_MAX = GAIN_MAX_INT[GAIN_W-1:0];
  localparam logic [RECIP_W-1:0] RECIP_M  = RECIP_M_INT[RECIP_W-1:0];
  localparam logic [CH_W-1:0]    CH_MAX   = {CH_W{1'b1}};
  localparam logic [REG_W-1:0]   RAD_MIN  = {{(REG_W-1){1'b0}}, 1'b1};

  localparam int unsigned WIDTH_RST_INT  = 640;
  localparam int unsigned HEIGHT_RST_INT = 480;
  localparam int unsigned RADIUS_RST_INT = 336;
  localparam logic [REG_W-1:0] WIDTH_RST  = WIDTH_RST_INT[REG_W-1:0];
  localparam logic [REG_W-1:0] HEIGHT_RST = HEIGHT_RST_INT[REG_W-1:0];
  localparam logic [REG_W-1:0] RADIUS_RST = RADIUS_RST_INT[REG_W-1:0];

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_col;
    logic [COORD_BITS-1:0] pixel_row;
    logic [CH_W-1:0]       in_blue;
    logic [CH_W-1:0]       in_green;
    logic [CH_W-1:0]       in_red;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
  } pix_out_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

endpackage

FILE: sv/radial_vignette_pixel_top.sv
// Stages: 3 distance stages, 21 square-root stages, 16 divider stages, 4 gain stages.
// Throughput: one pixel per cycle while the output is not stalled.
// The square root and the divider retire one bit per stage.
// A stall at the output freezes the whole pipeline; the input skid register takes one more item.
// Reset clears all valid bits and loads width 640, height 480, corner radius 336.
// Top level: configuration registers, input skid, distance-squared stages and pipeline glue.
`include "assert_macros.svh"

module radial_vignette_pixel_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rvp_pkg::pix_in_t              in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output rvp_pkg::pix_out_t             out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rvp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rvp_pkg::REG_W-1:0]     cfg_data_i
);
  import rvp_pkg::*;

  logic [REG_W-1:0] width_q;
  logic [REG_W-1:0] height_q;
  logic [REG_W-1:0] radius_q;
  logic [REG_W-1:0] rad;

  logic    pipe_adv;
  logic    in_accept;
  logic    skid_v_q;
  logic    skid_v_d;
  pix_in_t skid_q;
  pix_in_t src_item;
  logic    src_valid;
  rgb_t    src_rgb;

  logic signed [DIFF_W-1:0]   dx_d;
  logic signed [DIFF_W-1:0]   dy_d;
  logic signed [DIFF_W-1:0]   dx_q;
  logic signed [DIFF_W-1:0]   dy_q;
  logic signed [2*DIFF_W-1:0] prod_x;
  logic signed [2*DIFF_W-1:0] prod_y;
  logic [SQ_W-1:0]            sqx_q;
  logic [SQ_W-1:0]            sqy_q;
  logic [SUM_W-1:0]           sum_q;
  logic                       va_q;
  logic                       vb_q;
  logic                       vc_q;
  rgb_t                       rgb_a_q;
  rgb_t                       rgb_b_q;
  rgb_t                       rgb_c_q;

  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  rgb_t              sq_rgb;
  logic              dv_valid;
  logic [QUO_W-1:0]  dv_quo;
  logic              dv_ovf;
  rgb_t              dv_rgb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      radius_q <= RADIUS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        CFG_RADIUS: radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rad = (radius_q == '0) ? RAD_MIN : radius_q;

  // whole pipeline moves unless the output item is held
  assign pipe_adv   = !out_valid_o || !out_stall_i;
  assign in_stall_o = skid_v_q;
  assign in_accept  = in_valid_i && !skid_v_q;
  assign skid_v_d   = pipe_adv ? 1'b0 : (skid_v_q || in_accept);

  assign src_item  = skid_v_q ? skid_q : in_item_i;
  assign src_valid = skid_v_q || in_valid_i;

  always_comb begin
    src_rgb.blue  = src_item.in_blue;
    src_rgb.green = src_item.in_green;
    src_rgb.red   = src_item.in_red;
  end

  assign dx_d = $signed({1'b0, src_item.pixel_col}) - $signed({1'b0, width_q[REG_W-1:1]});
  assign dy_d = $signed({1'b0, src_item.pixel_row}) - $signed({1'b0, height_q[REG_W-1:1]});

  assign prod_x = dx_q * dx_q;
  assign prod_y = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
      if (pipe_adv) begin
        va_q <= src_valid;
        vb_q <= va_q;
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && !pipe_adv) begin
      skid_q <= in_item_i;
    end
    if (pipe_adv) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      rgb_a_q <= src_rgb;
      sqx_q   <= prod_x[SQ_W-1:0];
      sqy_q   <= prod_y[SQ_W-1:0];
      rgb_b_q <= rgb_a_q;
      sum_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
      rgb_c_q <= rgb_b_q;
    end
  end

  rvp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (pipe_adv),
    .valid_i (vc_q),
    .sum_i   (sum_q),
    .rgb_i   (rgb_c_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .rgb_o   (sq_rgb)
  );

  rvp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (pipe_adv),
    .valid_i (sq_valid),
    .root_i  (sq_root),
    .rad_i   (rad),
    .rgb_i   (sq_rgb),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .ovf_o   (dv_ovf),
    .rgb_o   (dv_rgb)
  );

  rvp_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (pipe_adv),
    .valid_i (dv_valid),
    .quo_i   (dv_quo),
    .ovf_i   (dv_ovf),
    .rgb_i   (dv_rgb),
    .valid_o (out_valid_o),
    .pix_o   (out_item_o)
  );

  // the skid only fills while the output item is being held
  `RVP_ASSERT(a_skid_cause, skid_v_q |-> $past(out_valid_o && out_stall_i), "skid full without an output stall")
  `RVP_ASSERT(a_front_hold, !pipe_adv |=> $stable(va_q) && $stable(dx_q) && $stable(dy_q), "front stage moved during a stall")

endmodule

FILE: sv/rvp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`include "assert_macros.svh"

module rvp_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  logic [rvp_pkg::SUM_W-1:0]  sum_i,
  input  rvp_pkg::rgb_t              rgb_i,
  output logic                       valid_o,
  output logic [rvp_pkg::ROOT_W-1:0] root_o,
  output rvp_pkg::rgb_t              rgb_o
);
  import rvp_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_step_t;

  function automatic sq_step_t sq_step(input logic [REM_W-1:0] rem_in,
                                       input logic [ROOT_W-1:0] root_in,
                                       input logic [1:0] pair);
    logic [REM_W-1:0] rem_t;
    logic [REM_W-1:0] trial;
    logic             geq;
    sq_step_t         res;
    rem_t    = {rem_in[REM_W-3:0], pair};
    trial    = {root_in, 2'b01};
    geq      = (rem_t >= trial);
    res.rem  = geq ? (rem_t - trial) : rem_t;
    res.root = {root_in[ROOT_W-2:0], geq};
    return res;
  endfunction

  logic [RADICAND_W-1:0] radicand;
  logic [ROOT_W-1:0]     v_q;
  logic [REM_W-1:0]      rem_q  [ROOT_W];
  logic [ROOT_W-1:0]     root_q [ROOT_W];
  logic [REM_W-1:0]      rem_d  [ROOT_W];
  logic [ROOT_W-1:0]     root_d [ROOT_W];
  logic [RADICAND_W-1:0] rad_q  [ROOT_W-1];
  rgb_t                  rgb_q  [ROOT_W];

  assign radicand = {1'b0, sum_i, {(2 * DIST_FRAC){1'b0}}};

  always_comb begin
    sq_step_t st;
    st        = sq_step('0, '0, radicand[RADICAND_W-1 -: 2]);
    rem_d[0]  = st.rem;
    root_d[0] = st.root;
    for (int k = 1; k < ROOT_W; k++) begin
      st        = sq_step(rem_q[k-1], root_q[k-1], rad_q[k-1][RADICAND_W-1 -: 2]);
      rem_d[k]  = st.rem;
      root_d[k] = st.root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[ROOT_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rgb_q[0] <= rgb_i;
      rad_q[0] <= radicand << 2;
      for (int k = 0; k < ROOT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
      for (int k = 1; k < ROOT_W; k++) begin
        rgb_q[k] <= rgb_q[k-1];
      end
      for (int k = 1; k < ROOT_W - 1; k++) begin
        rad_q[k] <= rad_q[k-1] << 2;
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign rgb_o   = rgb_q[ROOT_W-1];

  // floor root leaves a remainder of at most twice the root
  `RVP_ASSERT_NEVER(a_sqrt_rem_bound, valid_o && (rem_q[ROOT_W-1] > {1'b0, root_o, 1'b0}), "sqrt remainder exceeds twice the root")

endmodule

FILE: sv/rvp_div.sv
// Pipelined restoring divider: scaled distance over corner radius.
`include "assert_macros.svh"

module rvp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  logic [rvp_pkg::ROOT_W-1:0] root_i,
  input  logic [rvp_pkg::REG_W-1:0]  rad_i,
  input  rvp_pkg::rgb_t              rgb_i,
  output logic                       valid_o,
  output logic [rvp_pkg::QUO_W-1:0]  quo_o,
  output logic                       ovf_o,
  output rvp_pkg::rgb_t              rgb_o
);
  import rvp_pkg::*;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic              qbit;
  } dv_step_t;

  function automatic dv_step_t dv_step(input logic [DREM_W-1:0] rem_in,
                                       input logic nbit,
                                       input logic [REG_W-1:0] den);
    logic [DREM_W-1:0] rem_t;
    logic              geq;
    dv_step_t          res;
    rem_t    = {rem_in[DREM_W-2:0], nbit};
    geq      = (rem_t >= {1'b0, den});
    res.rem  = geq ? (rem_t - {1'b0, den}) : rem_t;
    res.qbit = geq;
    return res;
  endfunction

  logic [ROOT_W+NUM_SHIFT-1:0] num;
  logic [QUO_W-1:0]            low0;
  logic [DREM_W-1:0]           rem0;
  logic                        ovf0;
  logic [QUO_W-1:0]            v_q;
  logic [DREM_W-1:0]           rem_q [QUO_W];
  logic [QUO_W-1:0]            quo_q [QUO_W];
  logic [DREM_W-1:0]           rem_d [QUO_W];
  logic [QUO_W-1:0]            quo_d [QUO_W];
  logic [QUO_W-1:0]            low_q [QUO_W-1];
  logic                        ovf_q [QUO_W];
  rgb_t                        rgb_q [QUO_W];

  // quotient needs QUO_W bits unless the numerator reaches rad << QUO_W
  assign num  = {root_i, {NUM_SHIFT{1'b0}}};
  assign low0 = num[QUO_W-1:0];
  assign rem0 = {2'b00, root_i[ROOT_W-1:DIV_PRE]};
  assign ovf0 = ({{REG_W{1'b0}}, root_i} >=
                 {{(CMP_W-REG_W-DIV_PRE){1'b0}}, rad_i, {DIV_PRE{1'b0}}});

  always_comb begin
    dv_step_t st;
    st       = dv_step(rem0, low0[QUO_W-1], rad_i);
    rem_d[0] = st.rem;
    quo_d[0] = {{(QUO_W-1){1'b0}}, st.qbit};
    for (int k = 1; k < QUO_W; k++) begin
      st       = dv_step(rem_q[k-1], low_q[k-1][QUO_W-1], rad_i);
      rem_d[k] = st.rem;
      quo_d[k] = {quo_q[k-1][QUO_W-2:0], st.qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ovf_q[0] <= ovf0;
      rgb_q[0] <= rgb_i;
      low_q[0] <= low0 << 1;
      for (int k = 0; k < QUO_W; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
      end
      for (int k = 1; k < QUO_W; k++) begin
        ovf_q[k] <= ovf_q[k-1];
        rgb_q[k] <= rgb_q[k-1];
      end
      for (int k = 1; k < QUO_W - 1; k++) begin
        low_q[k] <= low_q[k-1] << 1;
      end
    end
  end

  assign valid_o = v_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign ovf_o   = ovf_q[QUO_W-1];
  assign rgb_o   = rgb_q[QUO_W-1];

  `RVP_ASSERT(a_div_rem_below_den, valid_o && !ovf_o |-> rem_q[QUO_W-1] < {1'b0, rad_i}, "divider remainder not below divisor")

endmodule

FILE: sv/rvp_gain.sv
// Gain stages: clamp scale, form the gain and apply it to the three channels.
`include "assert_macros.svh"

module rvp_gain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  logic [rvp_pkg::QUO_W-1:0] quo_i,
  input  logic                      ovf_i,
  input  rvp_pkg::rgb_t             rgb_i,
  output logic                      valid_o,
  output rvp_pkg::pix_out_t         pix_o
);
  import rvp_pkg::*;

  function automatic logic [CH_W-1:0] sat_ch(input logic [CHPROD_W-1:0] prod);
    logic [CHPROD_W-FRAC_BITS-1:0] hi;
    hi = prod[CHPROD_W-1:FRAC_BITS];
    return (hi > {{(CHPROD_W-FRAC_BITS-CH_W){1'b0}}, CH_MAX}) ? CH_MAX : hi[CH_W-1:0];
  endfunction

  logic [3:0]              v_q;
  logic [QUO_W-1:0]        qc;
  logic [QUO_W-1:0]        diff;
  logic [NEAR_W-1:0]       near_n;
  logic                    near_d;
  logic [RECIP_PROD_W-1:0] tprod_d;
  logic [TENTH_W-1:0]      tenth;
  logic [GAIN_W-1:0]       g_d;

  logic [QUO_W-1:0]        qc_q;
  logic                    near_q;
  logic [RECIP_PROD_W-1:0] tprod_q;
  logic [GAIN_W-1:0]       g_q;
  logic [CHPROD_W-1:0]     pb_q;
  logic [CHPROD_W-1:0]     pg_q;
  logic [CHPROD_W-1:0]     pr_q;
  rgb_t                    rgb1_q;
  rgb_t                    rgb2_q;
  pix_out_t                pix_q;

  // clamp scale at two, then take a tenth of the distance below one
  always_comb begin
    qc      = (ovf_i || (quo_i > TWO_Q)) ? TWO_Q : quo_i;
    near_d  = (qc < ONE_Q);
    diff    = ONE_Q - qc;
    near_n  = near_d ? diff[NEAR_W-1:0] : '0;
    tprod_d = {{RECIP_W{1'b0}}, near_n} * {{NEAR_W{1'b0}}, RECIP_M};
  end

  always_comb begin
    tenth = tprod_q[RECIP_PROD_W-1:RECIP_K];
    g_d   = near_q ? (ONE_Q + {{(GAIN_W-TENTH_W){1'b0}}, tenth}) : (TWO_Q - qc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      qc_q    <= qc;
      near_q  <= near_d;
      tprod_q <= tprod_d;
      rgb1_q  <= rgb_i;
      g_q     <= g_d;
      rgb2_q  <= rgb1_q;
      pb_q    <= {{GAIN_W{1'b0}}, rgb2_q.blue}  * {{CH_W{1'b0}}, g_q};
      pg_q    <= {{GAIN_W{1'b0}}, rgb2_q.green} * {{CH_W{1'b0}}, g_q};
      pr_q    <= {{GAIN_W{1'b0}}, rgb2_q.red}   * {{CH_W{1'b0}}, g_q};
      pix_q.out_blue  <= sat_ch(pb_q);
      pix_q.out_green <= sat_ch(pg_q);
      pix_q.out_red   <= sat_ch(pr_q);
    end
  end

  assign valid_o = v_q[3];
  assign pix_o   = pix_q;

  `RVP_ASSERT(a_gain_bound, v_q[1] |-> g_q <= GAIN_MAX, "gain above its upper bound")

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for radial_vignette_pixel_top: directed and random pixels against a fixed-point model.
module tb_top;
  import rvp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned SQUEEZE_RUN  = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam longint unsigned UNITY = 64'd1 << FRAC_BITS;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE,
    STALL_SPARSE
  } stall_mode_e;

  class vignette_scoreboard;
    logic [REG_W-1:0] frame_w;
    logic [REG_W-1:0] frame_h;
    logic [REG_W-1:0] radius;
    pix_out_t expected_pixels[$];
    int errors;

    function new();
      frame_w = WIDTH_RST;
      frame_h = HEIGHT_RST;
      radius  = RADIUS_RST;
      errors  = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        CFG_WIDTH:  frame_w = val;
        CFG_HEIGHT: frame_h = val;
        CFG_RADIUS: radius  = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= v) root = cand;
      end
      return root;
    endfunction

    function logic [CH_W-1:0] scale_channel(logic [CH_W-1:0] ch, longint unsigned gain);
      longint unsigned prod;
      prod = (64'(ch) * gain) >> FRAC_BITS;
      return (prod > 64'(CH_MAX)) ? CH_MAX : prod[CH_W-1:0];
    endfunction

    function pix_out_t shade_pixel(pix_in_t p);
      longint col_pos, row_pos, ctr_x, ctr_y, dx, dy, tilt;
      longint unsigned dist_sq, dist_fx, rad, ratio, gain;
      pix_out_t res;
      col_pos = longint'(p.pixel_col);
      row_pos = longint'(p.pixel_row);
      ctr_x   = longint'(frame_w[REG_W-1:1]);
      ctr_y   = longint'(frame_h[REG_W-1:1]);
      dx      = col_pos - ctr_x;
      dy      = row_pos - ctr_y;
      dist_sq = dx * dx + dy * dy;
      dist_fx = int_sqrt(dist_sq << (2 * DIST_FRAC));
      rad     = (radius == '0) ? 64'd1 : 64'(radius);
      ratio   = (dist_fx << (FRAC_BITS + 1)) / (rad << DIST_FRAC);
      if (ratio > 2 * UNITY) ratio = 2 * UNITY;
      tilt = ratio - UNITY;
      // near the centre: divide the tilt by ten, rounding toward zero
      if (tilt < 0) tilt = -((-tilt) / 10);
      gain = UNITY - tilt;
      res.out_blue  = scale_channel(p.in_blue, gain);
      res.out_green = scale_channel(p.in_green, gain);
      res.out_red   = scale_channel(p.in_red, gain);
      return res;
    endfunction

    function void note_pixel(pix_in_t p);
      expected_pixels.push_back(shade_pixel(p));
    endfunction

    function void compare_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_pixel(pix_out_t got);
      pix_out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_channel("blue", want.out_blue, got.out_blue);
      compare_channel("green", want.out_green, got.out_green);
      compare_channel("red", want.out_red, got.out_red);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pix_in_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pix_out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_data = '0;

  bit hold_req = 1'b0;
  int unsigned cycle_count = 0;
  vignette_scoreboard sb;

  always #10 clk_i = ~clk_i;

  radial_vignette_pixel_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_pixel(in_item);
      if (out_valid && !out_stall) sb.check_pixel(out_item);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: segments of stall patterns, plus one long hold-off on request.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        mode = stall_mode_e'($urandom_range(0, 4));
        len  = $urandom_range(8, 40);
        repeat (len) begin
          case (mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
            STALL_TOGGLE: out_stall <= ~out_stall;
            default:      out_stall <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_pixel(pix_in_t p);
    in_valid <= 1'b1;
    in_item  <= p;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_idle();
    while (sb.expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [REG_W-1:0] w, logic [REG_W-1:0] h, logic [REG_W-1:0] r);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [REG_W-1:0] val [4];
    idx = '{CFG_WIDTH, CFG_HEIGHT, CFG_RADIUS, CFG_UNMAPPED};
    val = '{w, h, r, REG_W'($urandom_range(0, 8191))};
    cfg_valid <= 1'b1;
    for (int k = 0; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk_i); while (!cfg_ready);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic pix_in_t random_pixel(logic [REG_W-1:0] w, logic [REG_W-1:0] h);
    pix_in_t p;
    int unsigned col_hi, row_hi, pick;
    col_hi = (w == '0 || w > 13'd4096) ? 4095 : 32'(w) - 1;
    row_hi = (h == '0 || h > 13'd4096) ? 4095 : 32'(h) - 1;
    if ($urandom_range(0, 3) == 0) begin
      p.pixel_col = COORD_BITS'($urandom_range(0, 4095));
      p.pixel_row = COORD_BITS'($urandom_range(0, 4095));
    end else begin
      p.pixel_col = COORD_BITS'($urandom_range(0, col_hi));
      p.pixel_row = COORD_BITS'($urandom_range(0, row_hi));
    end
    pick = $urandom_range(0, 5);
    if (pick == 0) begin
      p.in_blue = CH_MAX; p.in_green = CH_MAX; p.in_red = CH_MAX;
    end else if (pick == 1) begin
      p.in_blue = '0; p.in_green = '0; p.in_red = '0;
    end else begin
      p.in_blue  = CH_W'($urandom_range(0, 255));
      p.in_green = CH_W'($urandom_range(0, 255));
      p.in_red   = CH_W'($urandom_range(0, 255));
    end
    return p;
  endfunction

  task automatic run_phase(int unsigned count, logic [REG_W-1:0] w, logic [REG_W-1:0] h,
                           logic [REG_W-1:0] r, bit reprogram, bit squeeze);
    int unsigned burst_left, gap;
    if (reprogram) program_regs(w, h, r);
    burst_left = squeeze ? SQUEEZE_RUN : $urandom_range(1, 40);
    // keep offering back to back while the receiver holds off
    if (squeeze) hold_req = 1'b1;
    repeat (count) begin
      send_pixel(random_pixel(sb.frame_w, sb.frame_h));
      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 40);
      end
    end
    in_valid <= 1'b0;
    wait_idle();
  endtask

  initial begin
    int unsigned w, h, big, r;
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: centre (320,240), radius 336
    send_pixel(pix_in_t'{12'd320, 12'd240, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd320, 12'd240, 8'd128, 8'd64, 8'd1});
    send_pixel(pix_in_t'{12'd321, 12'd240, 8'd200, 8'd100, 8'd50});
    send_pixel(pix_in_t'{12'd323, 12'd244, 8'd255, 8'd0, 8'd255});
    send_pixel(pix_in_t'{12'd420, 12'd240, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd488, 12'd240, 8'd255, 8'd17, 8'd99});
    send_pixel(pix_in_t'{12'd490, 12'd240, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd320, 12'd576, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd0, 12'd0, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd4095, 12'd0, 8'd1, 8'd2, 8'd3});
    send_pixel(pix_in_t'{12'd0, 12'd4095, 8'd128, 8'd128, 8'd128});
    send_pixel(pix_in_t'{12'd320, 12'd0, 8'd255, 8'd255, 8'd255});
    send_pixel(pix_in_t'{12'd560, 12'd420, 8'd77, 8'd188, 8'd240});
    send_pixel(pix_in_t'{12'd100, 12'd300, 8'd0, 8'd0, 8'd0});
    send_pixel(pix_in_t'{12'd330, 12'd250, 8'hAA, 8'h55, 8'hFF});
    in_valid <= 1'b0;
    wait_idle();

    run_phase(200, WIDTH_RST, HEIGHT_RST, RADIUS_RST, 1'b0, 1'b1);
    run_phase(100, 13'h1FFF, 13'h1FFF, 13'd1, 1'b1, 1'b0);
    run_phase(100, 13'd1, 13'd1, 13'd4096, 1'b1, 1'b0);
    // zero radius acts as one
    run_phase(100, 13'd640, 13'd480, 13'd0, 1'b1, 1'b0);
    run_phase(90, 13'd0, 13'd0, 13'h1FFF, 1'b1, 1'b0);
    run_phase(90, 13'd4096, 13'd4096, 13'd2155, 1'b1, 1'b0);
    for (int ph = 0; ph < 3; ph++) begin
      w   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      h   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
      big = (w > h) ? w : h;
      r   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : big * 10 / 19;
      run_phase(90, REG_W'(w), REG_W'(h), REG_W'(r), 1'b1, 1'b0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/rvp_pkg.sv
sv/rvp_sqrt.sv
sv/rvp_div.sv
sv/rvp_gain.sv
sv/radial_vignette_pixel_top.sv
bench/tb_top.sv
